>>> src/button_hold_feedback_fader_defines.svh
// Assertion macros shared by the fader RTL.
// Included by button_hold_feedback_fader; no other dependencies.
`ifndef BUTTON_HOLD_FEEDBACK_FADER_DEFINES_SVH
`define BUTTON_HOLD_FEEDBACK_FADER_DEFINES_SVH
// Implication checked on every edge outside reset.
`define BHF_ASSERT_IMP(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("bhf check failed");
// Next-cycle implication.
`define BHF_ASSERT_NXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("bhf check failed");
`endif

>>> src/bhf_pkg.sv
// Package for the button hold feedback fader: payload types and constants.
// No dependencies.
`default_nettype none
package bhf_pkg;
  localparam int NUM_KEYS = 3;
  localparam int KEY_W = 2;

  localparam logic [2:0] CMD_INIT  = 3'd0;
  localparam logic [2:0] CMD_EVENT = 3'd1;
  localparam logic [2:0] CMD_CTX   = 3'd2;
  localparam logic [2:0] CMD_QUERY = 3'd3;
  localparam logic [2:0] CMD_FRAME = 3'd4;

  localparam logic [2:0] EV_PRESS   = 3'd0;
  localparam logic [2:0] EV_RELEASE = 3'd1;
  localparam logic [2:0] EV_LONG    = 3'd2;
  localparam logic [2:0] EV_VLONG   = 3'd3;

  localparam logic [1:0] REG_LONG_PRESS = 2'd0;
  localparam logic [1:0] REG_REL_WIN    = 2'd1;
  localparam logic [1:0] REG_FADE       = 2'd2;
  localparam logic [1:0] REG_IDLE       = 2'd3;

  localparam logic [10:0] Q_ONE = 11'd1024;
  localparam logic [11:0] EASE_K = 12'd3072;
  localparam logic [7:0] ALPHA_FULL = 8'd255;

  typedef struct packed {
    logic [2:0]  cmd;
    logic [1:0]  key_index;
    logic [2:0]  event_kind;
    logic [31:0] time_ms;
    logic [31:0] hold_duration_ms;
    logic [31:0] scene_scope;
    logic [31:0] scene_generation;
    logic        scene_enable;
    logic        want_long;
    logic [2:0]  boot_held_mask;
  } bhf_in_t;

  typedef struct packed {
    logic [1:0] key_phase;
    logic [1:0] action_phase;
    logic [7:0] opacity;
  } bhf_out_t;
endpackage
`default_nettype wire

>>> src/button_hold_feedback_fader.sv
// Button hold feedback fader; depends on bhf_pkg and button_hold_feedback_fader_defines.svh.
// Flow: a non-frame item is executed and its result is offered; a frame item runs an
// 11-step restoring divider for the fade fraction, then a shared 32x32 multiplier
// for the smoothstep and the blend, and skips the divider when the fade has already run out.
// in_stall holds until the result is taken, so a new item is taken only after the last one is out.
// Reset (rst_n, synchronous) clears the control and scene state and loads register defaults.
`default_nettype none
`include "button_hold_feedback_fader_defines.svh"
module button_hold_feedback_fader (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_stall,
  input  wire bhf_pkg::bhf_in_t in_data,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output bhf_pkg::bhf_out_t     out_data,
  input  wire logic             cfg_psel,
  input  wire logic             cfg_penable,
  input  wire logic             cfg_pwrite,
  input  wire logic [3:0]       cfg_paddr,
  input  wire logic [31:0]      cfg_pwdata,
  output logic [31:0]           cfg_prdata,
  output logic                  cfg_pready
);
  import bhf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE, S_EXEC, S_DIV, S_M1, S_M2, S_M3, S_FIN, S_OUT
  } state_t;

  state_t state_r;
  bhf_in_t it_r;
  bhf_out_t res_r;
  logic [15:0] long_press_r, rel_win_r, fade_r, idle_r;

  logic [NUM_KEYS-1:0] blocked_r, key_down_r, key_long_r, rel_long_r, has_rel_r;
  logic feedback_on_r, had_act_r, fade_started_r;
  logic [31:0] cur_scope_r, cur_gen_r, last_act_r, fade_start_r;
  logic [7:0] alpha_now_r, alpha_from_r, alpha_goal_r;
  logic [31:0] p_scope_r [NUM_KEYS];
  logic [31:0] p_gen_r [NUM_KEYS];
  logic [31:0] rel_time_r [NUM_KEYS];
  logic [31:0] rel_scope_r [NUM_KEYS];

  // Divider and multiplier working registers.
  logic [31:0] age_r;
  logic [3:0] cnt_r;
  logic [16:0] rem_r;
  logic [10:0] q_r;
  logic [63:0] prod_r;

  // Shared multiplier.
  logic [31:0] mul_a, mul_b;
  logic [63:0] mul_p;
  assign mul_p = mul_a * mul_b;

  logic [11:0] k2q;
  assign k2q = EASE_K - {q_r, 1'b0};
  logic signed [9:0] dgoal;
  assign dgoal = $signed({2'b0, alpha_goal_r}) - $signed({2'b0, alpha_from_r});

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_M1: begin
        mul_a = {21'd0, q_r};
        mul_b = {21'd0, q_r};
      end
      S_M2: begin
        mul_a = prod_r[31:0];
        mul_b = {20'd0, k2q};
      end
      S_M3: begin
        // |dgoal| times ease, sign applied after.
        mul_a = {22'd0, (dgoal < 0) ? 10'(-dgoal) : dgoal};
        mul_b = {21'd0, prod_r[30:20]};
      end
      default: ;
    endcase
  end

  logic kvalid;
  logic [KEY_W-1:0] k;
  assign k = it_r.key_index;
  assign kvalid = 32'(k) < NUM_KEYS;

  logic [16:0] rem_sh;
  assign rem_sh = {rem_r[15:0], 1'b0};

  logic [31:0] idle_age;
  assign idle_age = it_r.time_ms - last_act_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      long_press_r <= 16'd1000;
      rel_win_r <= 16'd1000;
      fade_r <= 16'd300;
      idle_r <= 16'd5000;
      blocked_r <= '0; key_down_r <= '0; key_long_r <= '0;
      rel_long_r <= '0; has_rel_r <= '0;
      feedback_on_r <= 1'b0; had_act_r <= 1'b0; fade_started_r <= 1'b0;
      cur_scope_r <= '0; cur_gen_r <= '0; last_act_r <= '0; fade_start_r <= '0;
      alpha_now_r <= '0; alpha_from_r <= '0; alpha_goal_r <= '0;
      for (int i = 0; i < NUM_KEYS; i++) begin
        p_scope_r[i] <= '0; p_gen_r[i] <= '0;
        rel_time_r[i] <= '0; rel_scope_r[i] <= '0;
      end
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite) begin
        case (cfg_paddr[3:2])
          REG_LONG_PRESS: long_press_r <= cfg_pwdata[15:0];
          REG_REL_WIN:    rel_win_r <= cfg_pwdata[15:0];
          REG_FADE:       fade_r <= cfg_pwdata[15:0];
          REG_IDLE:       idle_r <= cfg_pwdata[15:0];
          default: ;
        endcase
      end
      case (state_r)
        S_IDLE: begin
          if (in_valid) begin
            it_r <= in_data;
            state_r <= S_EXEC;
          end
        end
        S_EXEC: begin
          bhf_out_t res_v;
          logic frame_go;
          logic fade_done;
          res_v = '0;
          frame_go = (it_r.cmd == CMD_FRAME) && feedback_on_r &&
                     !(!had_act_r && fade_started_r);
          fade_done = (it_r.time_ms - fade_start_r) >= {16'd0, fade_r};
          // A frame that fades skips the divider once the fade has run out.
          state_r <= !frame_go ? S_OUT : (fade_done ? S_M1 : S_DIV);
          case (it_r.cmd)
            CMD_INIT: begin
              key_down_r <= '0; key_long_r <= '0; rel_long_r <= '0; has_rel_r <= '0;
              feedback_on_r <= 1'b0; had_act_r <= 1'b0; fade_started_r <= 1'b0;
              cur_scope_r <= '0; cur_gen_r <= '0; last_act_r <= '0;
              fade_start_r <= '0;
              alpha_now_r <= '0; alpha_from_r <= '0; alpha_goal_r <= '0;
              for (int i = 0; i < NUM_KEYS; i++) begin
                p_scope_r[i] <= '0; p_gen_r[i] <= '0;
                rel_time_r[i] <= '0; rel_scope_r[i] <= '0;
              end
              blocked_r <= it_r.boot_held_mask[NUM_KEYS-1:0];
            end
            CMD_EVENT: begin
              if (kvalid) begin
                if (blocked_r[k]) begin
                  if (it_r.event_kind == EV_RELEASE) blocked_r[k] <= 1'b0;
                end else begin
                  if ((it_r.event_kind == EV_PRESS && !key_down_r[k]) ||
                      (it_r.event_kind == EV_RELEASE && key_down_r[k])) begin
                    last_act_r <= it_r.time_ms;
                    had_act_r <= 1'b1;
                  end
                  if (it_r.event_kind == EV_PRESS) begin
                    if (!key_down_r[k]) begin
                      key_down_r[k] <= 1'b1;
                      key_long_r[k] <= 1'b0;
                      p_scope_r[k] <= cur_scope_r;
                      p_gen_r[k] <= feedback_on_r ? cur_gen_r : ~cur_gen_r;
                    end
                  end else if (it_r.event_kind == EV_RELEASE) begin
                    if (key_down_r[k] && feedback_on_r && p_scope_r[k] == cur_scope_r &&
                        p_gen_r[k] == cur_gen_r) begin
                      rel_time_r[k] <= it_r.time_ms;
                      rel_long_r[k] <= it_r.hold_duration_ms >= {16'd0, long_press_r};
                      rel_scope_r[k] <= cur_scope_r;
                      has_rel_r[k] <= 1'b1;
                    end
                    key_down_r[k] <= 1'b0;
                    key_long_r[k] <= 1'b0;
                  end else if ((it_r.event_kind == EV_LONG ||
                                it_r.event_kind == EV_VLONG) && key_down_r[k]) begin
                    key_long_r[k] <= 1'b1;
                  end
                end
              end
            end
            CMD_CTX: begin
              if (feedback_on_r && !it_r.scene_enable) begin
                blocked_r <= blocked_r | key_down_r;
                key_down_r <= '0; key_long_r <= '0; has_rel_r <= '0;
                alpha_now_r <= '0; alpha_from_r <= '0; alpha_goal_r <= '0;
                had_act_r <= 1'b0; fade_started_r <= 1'b1;
              end
              cur_scope_r <= it_r.scene_scope;
              cur_gen_r <= it_r.scene_generation;
              feedback_on_r <= it_r.scene_enable;
            end
            CMD_QUERY: begin
              if (kvalid) begin
                if (key_down_r[k] && feedback_on_r && p_scope_r[k] == it_r.scene_scope &&
                    p_gen_r[k] == cur_gen_r)
                  res_v.key_phase = key_long_r[k] ? 2'd2 : 2'd1;
                if (has_rel_r[k] && rel_scope_r[k] == it_r.scene_scope &&
                    rel_long_r[k] == it_r.want_long &&
                    (it_r.time_ms - rel_time_r[k]) < {16'd0, rel_win_r})
                  res_v.action_phase = rel_long_r[k] ? 2'd2 : 2'd1;
              end
            end
            CMD_FRAME: begin
              if (frame_go) begin
                if (!fade_started_r) begin
                  fade_started_r <= 1'b1;
                  if (!had_act_r) begin
                    last_act_r <= it_r.time_ms;
                    had_act_r <= 1'b1;
                  end
                end
                age_r <= it_r.time_ms - fade_start_r;
                rem_r <= '0;
                q_r <= fade_done ? Q_ONE : 11'd0;
                cnt_r <= 4'd10;
              end
            end
            default: ;
          endcase
          res_r <= res_v;
        end
        S_DIV: begin
          // Restoring division of age*1024 by fade_ms; age < fade_ms < 2^16.
          logic [16:0] r;
          r = (cnt_r == 4'd10) ? {1'b0, age_r[15:0]} : rem_sh;
          if (r >= {1'b0, fade_r}) begin
            rem_r <= r - {1'b0, fade_r};
            q_r <= {q_r[9:0], 1'b1};
          end else begin
            rem_r <= r;
            q_r <= {q_r[9:0], 1'b0};
          end
          if (cnt_r == 4'd0) state_r <= S_M1;
          else cnt_r <= cnt_r - 4'd1;
        end
        S_M1: begin
          prod_r <= mul_p;
          state_r <= S_M2;
        end
        S_M2: begin
          prod_r <= mul_p;
          state_r <= S_M3;
        end
        S_M3: begin
          prod_r <= mul_p;
          state_r <= S_FIN;
        end
        S_FIN: begin
          logic [9:0] mag;
          logic [7:0] an;
          logic [7:0] tgt;
          mag = prod_r[19:10];
          an = (dgoal < 0) ? alpha_from_r - mag[7:0] : alpha_from_r + mag[7:0];
          tgt = ((|key_down_r) || idle_age < {16'd0, idle_r}) ? ALPHA_FULL : 8'd0;
          alpha_now_r <= an;
          res_r.opacity <= an;
          if (tgt != alpha_goal_r) begin
            alpha_from_r <= an;
            alpha_goal_r <= tgt;
            fade_start_r <= it_r.time_ms;
          end
          state_r <= S_OUT;
        end
        S_OUT: begin
          if (!out_stall) state_r <= S_IDLE;
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state_r != S_IDLE);
  assign out_valid = (state_r == S_OUT);
  assign out_data = res_r;
  assign cfg_pready = 1'b1;

  always_comb begin
    case (cfg_paddr[3:2])
      REG_LONG_PRESS: cfg_prdata = {16'd0, long_press_r};
      REG_REL_WIN:    cfg_prdata = {16'd0, rel_win_r};
      REG_FADE:       cfg_prdata = {16'd0, fade_r};
      REG_IDLE:       cfg_prdata = {16'd0, idle_r};
      default:        cfg_prdata = '0;
    endcase
  end

  `BHF_ASSERT_IMP(a_one_side, out_valid, in_stall)
  `BHF_ASSERT_NXT(a_hold_out, out_valid && out_stall, out_valid && $stable(out_data))
  `BHF_ASSERT_IMP(a_phase_range, out_valid, out_data.key_phase != 2'd3)
endmodule
`default_nettype wire
